[rtl/rdcu_pkg.sv]
// ============================================================================
// rdcu_pkg
// Shared types and constants of the reaction-diffusion cell update unit.
// ============================================================================
`default_nettype none

package rdcu_pkg;

    // Concentration width and full-scale value
    localparam int unsigned DATA_W = 16;
    localparam logic [DATA_W-1:0] MAX_VAL = 16'hFFFF;

    // Configuration port widths
    localparam int unsigned CFG_IDX_W  = 8;
    localparam int unsigned CFG_DATA_W = 8;
    localparam int unsigned MODE_W     = 2;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_DIFFUSION_MODE = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_REACTION_MODE  = 8'd1;

    // Diffusion stencil codes
    localparam logic [MODE_W-1:0] DIFF_EVEN   = 2'd0;  // /5 and /12 stencils
    localparam logic [MODE_W-1:0] DIFF_CROSS  = 2'd1;  // neighbours only for U
    localparam logic [MODE_W-1:0] DIFF_WEIGHT = 2'd2;  // weighted /8 stencils
    localparam logic [MODE_W-1:0] DIFF_NONE   = 2'd3;  // unused: blur gives zero

    // Reaction gain set codes
    localparam logic [MODE_W-1:0] REACT_G4   = 2'd0;
    localparam logic [MODE_W-1:0] REACT_G3   = 2'd1;
    localparam logic [MODE_W-1:0] REACT_G2   = 2'd2;
    localparam logic [MODE_W-1:0] REACT_NONE = 2'd3;  // unused: no reaction

    // Feed and kill gains (scaled by 2^10)
    localparam logic [4:0] FEED_28 = 5'd28;
    localparam logic [4:0] FEED_27 = 5'd27;
    localparam logic [6:0] KILL_80 = 7'd80;
    localparam int unsigned GAIN_SHIFT = 10;

    // Reciprocal constants: x/5 = (x*DIV5_MULT)>>24 for x < 2^19,
    // y/3 = (y*DIV3_MULT)>>20 for y < 2^18
    localparam logic [21:0] DIV5_MULT  = 22'd3355444;
    localparam int unsigned DIV5_SHIFT = 24;
    localparam logic [19:0] DIV3_MULT  = 20'd349526;
    localparam int unsigned DIV3_SHIFT = 20;

    // Fixed-point fraction bits of the uvv product
    localparam int unsigned FRAC_BITS = 16;

    // Live configuration
    typedef struct packed {
        logic [MODE_W-1:0] diff_mode;
        logic [MODE_W-1:0] react_mode;
    } cfg_t;

endpackage : rdcu_pkg

`default_nettype wire

[rtl/rdcu_blur.sv]
// ============================================================================
// rdcu_blur
// Two pipeline stages: stencil sums, then the truncating stencil division.
// ============================================================================
`default_nettype none

module rdcu_blur
    import rdcu_pkg::*;
(
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire cfg_t              cfg,
    input  wire logic              s_valid,
    output logic                   s_ready,
    input  wire logic [DATA_W-1:0] s_u_center,
    input  wire logic [DATA_W-1:0] s_u_east,
    input  wire logic [DATA_W-1:0] s_u_west,
    input  wire logic [DATA_W-1:0] s_u_south,
    input  wire logic [DATA_W-1:0] s_u_north,
    input  wire logic [DATA_W-1:0] s_v_center,
    input  wire logic [DATA_W-1:0] s_v_east,
    input  wire logic [DATA_W-1:0] s_v_west,
    input  wire logic [DATA_W-1:0] s_v_south,
    input  wire logic [DATA_W-1:0] s_v_north,
    output logic                   out_valid,
    input  wire logic              out_ready,
    output logic [DATA_W-1:0]      out_bu,
    output logic [DATA_W-1:0]      out_bv
);

    localparam int unsigned SU_W = DATA_W + 3;  // up to 8x full scale
    localparam int unsigned SV_W = DATA_W + 4;  // up to 12x full scale

    logic            s1_valid_reg;
    logic [SU_W-1:0] su_reg, su_next;
    logic [SV_W-1:0] sv_reg, sv_next;
    logic            s2_valid_reg;
    logic [DATA_W-1:0] bu_reg, bu_next;
    logic [DATA_W-1:0] bv_reg, bv_next;
    logic            adv1, adv2;

    logic [SU_W-1:0] u_nbr_sum;
    logic [SV_W-1:0] v_nbr_sum;
    logic [40:0]     q5_prod;
    logic [17:0]     sv_quarter;
    logic [37:0]     q3_prod;

    // Stage enables: a stage moves when it is empty or its successor moves
    assign adv2    = !s2_valid_reg || out_ready;
    assign adv1    = !s1_valid_reg || adv2;
    assign s_ready = adv1;

    // Stage 1: stencil sums
    always_comb begin
        u_nbr_sum = SU_W'(s_u_east) + SU_W'(s_u_west) + SU_W'(s_u_south)
                  + SU_W'(s_u_north);
        v_nbr_sum = SV_W'(s_v_east) + SV_W'(s_v_west) + SV_W'(s_v_south)
                  + SV_W'(s_v_north);
        case (cfg.diff_mode)
            DIFF_EVEN: begin
                su_next = u_nbr_sum + SU_W'(s_u_center);
                sv_next = v_nbr_sum + (SV_W'(s_v_center) << 3);
            end
            DIFF_CROSS: begin
                su_next = u_nbr_sum;
                sv_next = v_nbr_sum + (SV_W'(s_v_center) << 2);
            end
            DIFF_WEIGHT: begin
                su_next = ((SU_W'(s_u_center) + SU_W'(s_u_east) + SU_W'(s_u_west)) << 1)
                        + SU_W'(s_u_south) + SU_W'(s_u_north);
                sv_next = v_nbr_sum + (SV_W'(s_v_center) << 2);
            end
            default: begin
                su_next = '0;
                sv_next = '0;
            end
        endcase
    end

    // Stage 2: divide by 5/12 through reciprocals, or shift by 4/8
    always_comb begin
        q5_prod    = 41'(su_reg) * 41'(DIV5_MULT);
        sv_quarter = sv_reg[SV_W-1:2];
        q3_prod    = 38'(sv_quarter) * 38'(DIV3_MULT);
        case (cfg.diff_mode)
            DIFF_EVEN: begin
                bu_next = q5_prod[DIV5_SHIFT +: DATA_W];
                bv_next = q3_prod[DIV3_SHIFT +: DATA_W];
            end
            DIFF_CROSS: begin
                bu_next = su_reg[2 +: DATA_W];
                bv_next = sv_reg[3 +: DATA_W];
            end
            DIFF_WEIGHT: begin
                bu_next = su_reg[3 +: DATA_W];
                bv_next = sv_reg[3 +: DATA_W];
            end
            default: begin
                bu_next = '0;
                bv_next = '0;
            end
        endcase
    end

    // Valid bits
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end else begin
            if (adv1) s1_valid_reg <= s_valid;
            if (adv2) s2_valid_reg <= s1_valid_reg;
        end
    end

    // Payload
    always_ff @(posedge aclk) begin
        if (adv1 && s_valid) begin
            su_reg <= su_next;
            sv_reg <= sv_next;
        end
        if (adv2 && s1_valid_reg) begin
            bu_reg <= bu_next;
            bv_reg <= bv_next;
        end
    end

    assign out_valid = s2_valid_reg;
    assign out_bu    = bu_reg;
    assign out_bv    = bv_reg;

endmodule : rdcu_blur

`default_nettype wire

[rtl/rdcu_reaction.sv]
// ============================================================================
// rdcu_reaction
// Three pipeline stages: uvv first product and feed/kill terms, uvv second
// product, then gain, update and clamp into the output register.
// ============================================================================
`default_nettype none

module rdcu_reaction
    import rdcu_pkg::*;
(
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire cfg_t              cfg,
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire logic [DATA_W-1:0] in_bu,
    input  wire logic [DATA_W-1:0] in_bv,
    output logic                   m_valid,
    input  wire logic              m_ready,
    output logic [DATA_W-1:0]      m_u_next,
    output logic [DATA_W-1:0]      m_v_next
);

    localparam int unsigned P1_W = 2 * DATA_W - 1;  // 15 x 16 bits
    localparam int unsigned FU_W = 11;              // (28*65535)>>10
    localparam int unsigned KV_W = 13;              // (80*65535)>>10
    localparam int unsigned ACC_W = DATA_W + 5;     // signed update range

    // Stage 3
    logic              s3_valid_reg;
    logic [P1_W-1:0]   p1_reg, p1_next;
    logic [DATA_W-1:0] s3_bu_reg, s3_bv_reg;
    logic [FU_W-1:0]   s3_fu_reg, fu_next;
    logic [KV_W-1:0]   s3_kv_reg, kv_next;
    // Stage 4
    logic              s4_valid_reg;
    logic [DATA_W-1:0] uvv_reg, uvv_next;
    logic [DATA_W-1:0] s4_bu_reg, s4_bv_reg;
    logic [FU_W-1:0]   s4_fu_reg;
    logic [KV_W-1:0]   s4_kv_reg;
    // Stage 5 (output)
    logic              out_valid_reg;
    logic [DATA_W-1:0] u_out_reg, u_out_next;
    logic [DATA_W-1:0] v_out_reg, v_out_next;

    logic adv3, adv4, adv5;

    logic [DATA_W-1:0]  u_room;
    logic [4:0]         feed_gain;
    logic [20:0]        feed_prod;
    logic [22:0]        kill_prod;
    logic [P1_W-1:0]    p2_prod;
    logic signed [ACC_W-1:0] du, dv, u_acc, v_acc;

    // Stage enables
    assign adv5     = !out_valid_reg || m_ready;
    assign adv4     = !s4_valid_reg || adv5;
    assign adv3     = !s3_valid_reg || adv4;
    assign in_ready = adv3;

    // Stage 3: (bu>>1)*bv, feed and kill terms
    always_comb begin
        p1_next   = P1_W'(in_bu[DATA_W-1:1]) * P1_W'(in_bv);
        u_room    = MAX_VAL - in_bu;
        feed_gain = (cfg.react_mode == REACT_G3) ? FEED_27 : FEED_28;
        feed_prod = 21'(u_room) * 21'(feed_gain);
        kill_prod = 23'(in_bv) * 23'(KILL_80);
        fu_next   = feed_prod[GAIN_SHIFT +: FU_W];
        kv_next   = kill_prod[GAIN_SHIFT +: KV_W];
    end

    // Stage 4: ((p1>>16)*bv)>>15
    always_comb begin
        p2_prod  = P1_W'(p1_reg[P1_W-1:FRAC_BITS]) * P1_W'(s3_bv_reg);
        uvv_next = p2_prod[FRAC_BITS-1 +: DATA_W];
    end

    // Stage 5: apply gains, update, clamp
    always_comb begin
        du = $signed(ACC_W'(s4_fu_reg)) - $signed(ACC_W'(uvv_reg));
        dv = $signed(ACC_W'(uvv_reg)) - $signed(ACC_W'(s4_kv_reg));
        case (cfg.react_mode)
            REACT_G4: begin
                u_acc = $signed(ACC_W'(s4_bu_reg)) + (du <<< 2);
                v_acc = $signed(ACC_W'(s4_bv_reg)) + (dv <<< 2);
            end
            REACT_G3: begin
                u_acc = $signed(ACC_W'(s4_bu_reg)) + (du <<< 1) + du;
                v_acc = $signed(ACC_W'(s4_bv_reg)) + (dv <<< 1) + dv;
            end
            REACT_G2: begin
                u_acc = $signed(ACC_W'(s4_bu_reg)) + (du <<< 1);
                v_acc = $signed(ACC_W'(s4_bv_reg)) + (dv <<< 1) + dv;
            end
            default: begin
                u_acc = $signed(ACC_W'(s4_bu_reg));
                v_acc = $signed(ACC_W'(s4_bv_reg));
            end
        endcase
        // clamp to 0..full scale
        if (u_acc < 0)                              u_out_next = '0;
        else if (u_acc > $signed(ACC_W'(MAX_VAL)))  u_out_next = MAX_VAL;
        else                                        u_out_next = u_acc[DATA_W-1:0];
        if (v_acc < 0)                              v_out_next = '0;
        else if (v_acc > $signed(ACC_W'(MAX_VAL)))  v_out_next = MAX_VAL;
        else                                        v_out_next = v_acc[DATA_W-1:0];
    end

    // Valid bits
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s3_valid_reg  <= 1'b0;
            s4_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (adv3) s3_valid_reg  <= in_valid;
            if (adv4) s4_valid_reg  <= s3_valid_reg;
            if (adv5) out_valid_reg <= s4_valid_reg;
        end
    end

    // Payload
    always_ff @(posedge aclk) begin
        if (adv3 && in_valid) begin
            p1_reg    <= p1_next;
            s3_bu_reg <= in_bu;
            s3_bv_reg <= in_bv;
            s3_fu_reg <= fu_next;
            s3_kv_reg <= kv_next;
        end
        if (adv4 && s3_valid_reg) begin
            uvv_reg   <= uvv_next;
            s4_bu_reg <= s3_bu_reg;
            s4_bv_reg <= s3_bv_reg;
            s4_fu_reg <= s3_fu_reg;
            s4_kv_reg <= s3_kv_reg;
        end
        if (adv5 && s4_valid_reg) begin
            u_out_reg <= u_out_next;
            v_out_reg <= v_out_next;
        end
    end

    assign m_valid  = out_valid_reg;
    assign m_u_next = u_out_reg;
    assign m_v_next = v_out_reg;

    // A held result keeps its value until the transfer
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(m_u_next) && $stable(m_v_next)))
        else $error("result changed while stalled");

    // Backpressure reaches the input only when every stage is full
    a_full_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        !in_ready |-> (s3_valid_reg && s4_valid_reg && out_valid_reg && !m_ready))
        else $error("input stalled with a free stage");

    // uvv can never exceed the blurred V it was formed from
    a_uvv_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        s4_valid_reg |-> (uvv_reg <= s4_bv_reg))
        else $error("uvv above blurred V");

endmodule : rdcu_reaction

`default_nettype wire

[rtl/reaction_diffusion_cell_update_unit.sv]
// ============================================================================
// reaction_diffusion_cell_update_unit
// Gray-Scott style cell update: five-point blur of U and V, uvv product,
// reaction gains and clamp to 0..65535.
// Pipeline: five register stages; the last is the output register.
// Throughput: one cell per cycle while m_ready holds no result back; each stage
// holds one item and moves on whenever its successor has room, so a stalled
// output fills the stages.
// Reset: synchronous active-low aresetn clears all valid bits and sets both
// mode registers to 0. Configuration writes take effect on the next cycle.
// ============================================================================
`default_nettype none

module reaction_diffusion_cell_update_unit
    import rdcu_pkg::*;
(
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    // configuration write channel
    input  wire logic                  cfg_valid,
    output logic                       cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data,
    // input cells
    input  wire logic                  s_valid,
    output logic                       s_ready,
    input  wire logic [DATA_W-1:0]     s_u_center,
    input  wire logic [DATA_W-1:0]     s_u_east,
    input  wire logic [DATA_W-1:0]     s_u_west,
    input  wire logic [DATA_W-1:0]     s_u_south,
    input  wire logic [DATA_W-1:0]     s_u_north,
    input  wire logic [DATA_W-1:0]     s_v_center,
    input  wire logic [DATA_W-1:0]     s_v_east,
    input  wire logic [DATA_W-1:0]     s_v_west,
    input  wire logic [DATA_W-1:0]     s_v_south,
    input  wire logic [DATA_W-1:0]     s_v_north,
    // results
    output logic                       m_valid,
    input  wire logic                  m_ready,
    output logic [DATA_W-1:0]          m_u_next,
    output logic [DATA_W-1:0]          m_v_next
);

    logic [MODE_W-1:0] diff_mode_reg;
    logic [MODE_W-1:0] react_mode_reg;
    cfg_t              cfg;

    logic              blur_valid;
    logic              blur_ready;
    logic [DATA_W-1:0] blur_u;
    logic [DATA_W-1:0] blur_v;

    // Configuration registers; unknown indexes are dropped
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            diff_mode_reg  <= DIFF_EVEN;
            react_mode_reg <= REACT_G4;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                REG_DIFFUSION_MODE: diff_mode_reg  <= cfg_data[MODE_W-1:0];
                REG_REACTION_MODE:  react_mode_reg <= cfg_data[MODE_W-1:0];
                default: ;
            endcase
        end
    end

    assign cfg.diff_mode  = diff_mode_reg;
    assign cfg.react_mode = react_mode_reg;

    // Blur stages
    rdcu_blur u_blur (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg        (cfg),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_u_center (s_u_center),
        .s_u_east   (s_u_east),
        .s_u_west   (s_u_west),
        .s_u_south  (s_u_south),
        .s_u_north  (s_u_north),
        .s_v_center (s_v_center),
        .s_v_east   (s_v_east),
        .s_v_west   (s_v_west),
        .s_v_south  (s_v_south),
        .s_v_north  (s_v_north),
        .out_valid  (blur_valid),
        .out_ready  (blur_ready),
        .out_bu     (blur_u),
        .out_bv     (blur_v)
    );

    // Reaction stages and output register
    rdcu_reaction u_reaction (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg      (cfg),
        .in_valid (blur_valid),
        .in_ready (blur_ready),
        .in_bu    (blur_u),
        .in_bv    (blur_v),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_u_next (m_u_next),
        .m_v_next (m_v_next)
    );

endmodule : reaction_diffusion_cell_update_unit

`default_nettype wire
